// ===== hw/rtl/bpsb_pkg.sv =====
// ----------------------------------------------------------------------------
// bpsb_pkg
// Widths, register indexes and constants of the box screen-bounds pipeline.
// ----------------------------------------------------------------------------
package bpsb_pkg;

    localparam int CW    = 25;  // corner coordinate, Q.8
    localparam int SQW   = 47;  // one squared feet coordinate
    localparam int DW    = 49;  // squared distance sum
    localparam int X1W   = 42;  // after yaw, Q.22
    localparam int YPW   = 41;  // y times pitch trig, Q.22
    localparam int PW    = 59;  // after pitch, Q.36
    localparam int XW    = 36;  // rounded x, Q.16
    localparam int YW    = 39;  // rounded y, Q.16
    localparam int ZW    = 39;  // rounded depth, Q.16
    localparam int NUMW  = 60;  // coordinate times focal
    localparam int MAGW  = 59;  // magnitude of that product
    localparam int QW    = 22;  // quotient bits kept, one per divider stage
    localparam int QSW   = 24;  // signed quotient
    localparam int REMW  = 40;  // divider partial remainder
    localparam int SW    = 26;  // screen coordinate before saturation
    localparam int IDXW  = 4;   // configuration index
    localparam int CFGW  = 40;  // configuration data

    localparam logic [IDXW-1:0] REG_COS_YAW     = 4'd0;
    localparam logic [IDXW-1:0] REG_SIN_YAW     = 4'd1;
    localparam logic [IDXW-1:0] REG_COS_PITCH   = 4'd2;
    localparam logic [IDXW-1:0] REG_SIN_PITCH   = 4'd3;
    localparam logic [IDXW-1:0] REG_FOCAL_PX    = 4'd4;
    localparam logic [IDXW-1:0] REG_MAX_DIST_SQ = 4'd5;
    localparam logic [IDXW-1:0] REG_SCREEN_W    = 4'd6;
    localparam logic [IDXW-1:0] REG_SCREEN_H    = 4'd7;

    // 0.1 block in Q.36
    localparam logic signed [PW-1:0] NEAR_Q36 = 59'sd6871947673;

    typedef struct packed {
        logic valid;
        logic last;
        logic use_c;
    } t_tag;

    typedef struct packed {
        t_tag            tag;
        logic            neg_x;
        logic            neg_y;
        logic            ovf_x;
        logic            ovf_y;
        logic [ZW-1:0]   z;
    } t_dside;

endpackage

// ===== hw/rtl/box_perspective_screen_bounds_unit.sv =====
// ----------------------------------------------------------------------------
// box_perspective_screen_bounds_unit
// Culls, rotates and projects the eight corners of a camera-relative box and
// returns its screen bounding rectangle with a visible flag.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall   | rel_x/y/z, box sizes
//  out     | output    | o_out_valid / i_out_stall | visible, screen rectangle
//  cfg     | input     | i_cfg_valid / o_cfg_ready | index, data
//
//  The eight corners of a box go one per cycle, while no output beat waits,
//  through a single rotate, multiply and 22-stage divide path. A new box is
//  accepted with the last corner of the previous one, before that box's result.
//  Reset restores the register defaults and empties the pipeline.
//  A waiting output beat freezes the whole pipeline; nothing is lost.
module box_perspective_screen_bounds_unit
    import bpsb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [23:0]      i_rel_x,
    input  logic signed [23:0]      i_rel_y,
    input  logic signed [23:0]      i_rel_z,
    input  logic [9:0]              i_half_width,
    input  logic [10:0]             i_box_height,
    input  logic [9:0]              i_half_depth,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_visible,
    output logic signed [15:0]      o_min_screen_x,
    output logic signed [15:0]      o_min_screen_y,
    output logic signed [15:0]      o_max_screen_x,
    output logic signed [15:0]      o_max_screen_y,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IDXW-1:0]         i_cfg_index,
    input  logic [CFGW-1:0]         i_cfg_data
);

    // configuration
    logic signed [15:0] r_cos_yaw, r_sin_yaw, r_cos_pitch, r_sin_pitch;
    logic [19:0]        r_focal;
    logic [39:0]        r_max_d;
    logic [13:0]        r_scr_w, r_scr_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_yaw   <= 16'sd16384;
            r_sin_yaw   <= 16'sd0;
            r_cos_pitch <= 16'sd16384;
            r_sin_pitch <= 16'sd0;
            r_focal     <= 20'd8192;
            r_max_d     <= 40'hFF_FFFF_FFFF;
            r_scr_w     <= 14'd1920;
            r_scr_h     <= 14'd1080;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COS_YAW:     r_cos_yaw   <= $signed(i_cfg_data[15:0]);
                REG_SIN_YAW:     r_sin_yaw   <= $signed(i_cfg_data[15:0]);
                REG_COS_PITCH:   r_cos_pitch <= $signed(i_cfg_data[15:0]);
                REG_SIN_PITCH:   r_sin_pitch <= $signed(i_cfg_data[15:0]);
                REG_FOCAL_PX:    r_focal     <= i_cfg_data[19:0];
                REG_MAX_DIST_SQ: r_max_d     <= i_cfg_data[39:0];
                REG_SCREEN_W:    r_scr_w     <= i_cfg_data[13:0];
                REG_SCREEN_H:    r_scr_h     <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // pipeline advance: hold everything while an output beat waits
    logic en;
    logic r_out_valid;
    assign en = !(r_out_valid && i_out_stall);

    // corner sequencer
    logic               r_busy;
    logic [2:0]         r_cnt;
    logic signed [23:0] r_bx, r_by, r_bz;
    logic [9:0]         r_hw, r_hd;
    logic [10:0]        r_ht;
    logic               take;

    assign take       = en && (!r_busy || r_cnt == 3'd7);
    assign o_in_stall = !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
        end else if (en) begin
            if (take) begin
                r_busy <= i_in_valid;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_in_valid) begin
            r_bx <= i_rel_x;
            r_by <= i_rel_y;
            r_bz <= i_rel_z;
            r_hw <= i_half_width;
            r_ht <= i_box_height;
            r_hd <= i_half_depth;
        end
    end

    // stage 1: corner coordinates and squared feet coordinates
    t_tag               r_s1_tag;
    logic signed [CW-1:0] r_s1_x, r_s1_y, r_s1_z;
    logic [SQW-1:0]     r_s1_qx, r_s1_qy, r_s1_qz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
        end else if (en) begin
            r_s1_tag.valid <= r_busy;
            r_s1_tag.last  <= (r_cnt == 3'd7);
            r_s1_tag.use_c <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [CW-1:0]  hw_s, ht_s, hd_s;
        logic signed [2*24-1:0] px, py, pz;
        hw_s = $signed({15'd0, r_hw});
        ht_s = $signed({14'd0, r_ht});
        hd_s = $signed({15'd0, r_hd});
        px = 48'(r_bx) * 48'(r_bx);
        py = 48'(r_by) * 48'(r_by);
        pz = 48'(r_bz) * 48'(r_bz);
        if (en) begin
            r_s1_x  <= CW'(r_bx) + (r_cnt[0] ? hw_s : -hw_s);
            r_s1_y  <= CW'(r_by) + (r_cnt[1] ? ht_s : CW'(0));
            r_s1_z  <= CW'(r_bz) + (r_cnt[2] ? hd_s : -hd_s);
            r_s1_qx <= px[SQW-1:0];
            r_s1_qy <= py[SQW-1:0];
            r_s1_qz <= pz[SQW-1:0];
        end
    end

    // stage 2: distance cull and yaw
    t_tag                  r_s2_tag;
    logic signed [X1W-1:0] r_s2_x1, r_s2_z1;
    logic signed [YPW-1:0] r_s2_ycp, r_s2_ysp;
    logic [DW-1:0]         feet_sq;

    assign feet_sq = DW'(r_s1_qx) + DW'(r_s1_qy) + DW'(r_s1_qz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_tag <= '0;
        end else if (en) begin
            r_s2_tag.valid <= r_s1_tag.valid;
            r_s2_tag.last  <= r_s1_tag.last;
            r_s2_tag.use_c <= r_s1_tag.use_c && (feet_sq <= DW'(r_max_d));
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [X1W-1:0] xe, ze, cy, sy;
        logic signed [YPW-1:0] ye, cp, sp;
        xe = X1W'(r_s1_x);
        ze = X1W'(r_s1_z);
        cy = X1W'(r_cos_yaw);
        sy = X1W'(r_sin_yaw);
        ye = YPW'(r_s1_y);
        cp = YPW'(r_cos_pitch);
        sp = YPW'(r_sin_pitch);
        if (en) begin
            r_s2_x1  <= xe * cy + ze * sy;
            r_s2_z1  <= ze * cy - xe * sy;
            r_s2_ycp <= ye * cp;
            r_s2_ysp <= ye * sp;
        end
    end

    // stage 3: pitch
    t_tag                 r_s3_tag;
    logic signed [PW-1:0] r_s3_y2, r_s3_z2;
    logic signed [XW-1:0] r_s3_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_tag <= '0;
        end else if (en) begin
            r_s3_tag <= r_s2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [PW-1:0]  z1e, cp, sp;
        logic signed [X1W-1:0] xr;
        z1e = PW'(r_s2_z1);
        cp  = PW'(r_cos_pitch);
        sp  = PW'(r_sin_pitch);
        xr  = (r_s2_x1 + X1W'(32)) >>> 6;
        if (en) begin
            r_s3_y2 <= (PW'(r_s2_ycp) <<< 14) + z1e * sp;
            r_s3_z2 <= z1e * cp - (PW'(r_s2_ysp) <<< 14);
            r_s3_x  <= xr[XW-1:0];
        end
    end

    // stage 4: near test and rounding to Q.16
    t_tag                 r_s4_tag;
    logic signed [XW-1:0] r_s4_x;
    logic signed [YW-1:0] r_s4_y;
    logic [ZW-1:0]        r_s4_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_tag <= '0;
        end else if (en) begin
            r_s4_tag.valid <= r_s3_tag.valid;
            r_s4_tag.last  <= r_s3_tag.last;
            r_s4_tag.use_c <= r_s3_tag.use_c && (r_s3_z2 > NEAR_Q36);
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [PW-1:0] yr, zr;
        yr = (r_s3_y2 + PW'(524288)) >>> 20;
        zr = (r_s3_z2 + PW'(524288)) >>> 20;
        if (en) begin
            r_s4_x <= r_s3_x;
            r_s4_y <= yr[YW-1:0];
            r_s4_z <= zr[ZW-1:0];
        end
    end

    // stage 5: scale by focal
    t_tag                   r_s5_tag;
    logic signed [NUMW-1:0] r_s5_nx, r_s5_ny;
    logic [ZW-1:0]          r_s5_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_tag <= '0;
        end else if (en) begin
            r_s5_tag <= r_s4_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [NUMW-1:0] fe;
        fe = $signed({{(NUMW-20){1'b0}}, r_focal});
        if (en) begin
            r_s5_nx <= NUMW'(r_s4_x) * fe;
            r_s5_ny <= NUMW'(r_s4_y) * fe;
            r_s5_z  <= r_s4_z;
        end
    end

    // stage 6: magnitude and sign
    t_tag             r_s6_tag;
    logic [MAGW-1:0]  r_s6_mx, r_s6_my;
    logic             r_s6_nx, r_s6_ny;
    logic [ZW-1:0]    r_s6_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_tag <= '0;
        end else if (en) begin
            r_s6_tag <= r_s5_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [NUMW-1:0] ax, ay;
        ax = r_s5_nx[NUMW-1] ? -r_s5_nx : r_s5_nx;
        ay = r_s5_ny[NUMW-1] ? -r_s5_ny : r_s5_ny;
        if (en) begin
            r_s6_mx <= ax[MAGW-1:0];
            r_s6_my <= ay[MAGW-1:0];
            r_s6_nx <= r_s5_nx[NUMW-1];
            r_s6_ny <= r_s5_ny[NUMW-1];
            r_s6_z  <= r_s5_z;
        end
    end

    // divider: restoring, one quotient bit per stage for x and y
    t_dside           r_d_side [0:QW];
    logic [REMW-1:0]  r_d_rx   [0:QW];
    logic [REMW-1:0]  r_d_ry   [0:QW];
    logic [QW-1:0]    r_d_lx   [0:QW];
    logic [QW-1:0]    r_d_ly   [0:QW];
    logic [QW-1:0]    r_d_qx   [0:QW];
    logic [QW-1:0]    r_d_qy   [0:QW];

    logic [MAGW-QW-1:0] hi_x, hi_y;
    assign hi_x = r_s6_mx[MAGW-1:QW];
    assign hi_y = r_s6_my[MAGW-1:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_side[0] <= '0;
        end else if (en) begin
            r_d_side[0].tag   <= r_s6_tag;
            r_d_side[0].neg_x <= r_s6_nx;
            r_d_side[0].neg_y <= r_s6_ny;
            r_d_side[0].ovf_x <= REMW'(hi_x) >= REMW'(r_s6_z);
            r_d_side[0].ovf_y <= REMW'(hi_y) >= REMW'(r_s6_z);
            r_d_side[0].z     <= r_s6_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_rx[0] <= REMW'(hi_x);
            r_d_ry[0] <= REMW'(hi_y);
            r_d_lx[0] <= r_s6_mx[QW-1:0];
            r_d_ly[0] <= r_s6_my[QW-1:0];
            r_d_qx[0] <= '0;
            r_d_qy[0] <= '0;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_side[k+1] <= '0;
            end else if (en) begin
                r_d_side[k+1] <= r_d_side[k];
            end
        end

        always_ff @(posedge i_clk) begin
            logic [REMW-1:0] tx, ty, zz;
            zz = REMW'(r_d_side[k].z);
            tx = {r_d_rx[k][REMW-2:0], r_d_lx[k][QW-1-k]};
            ty = {r_d_ry[k][REMW-2:0], r_d_ly[k][QW-1-k]};
            if (en) begin
                r_d_lx[k+1] <= r_d_lx[k];
                r_d_ly[k+1] <= r_d_ly[k];
                r_d_rx[k+1] <= (tx >= zz) ? tx - zz : tx;
                r_d_ry[k+1] <= (ty >= zz) ? ty - zz : ty;
                r_d_qx[k+1] <= {r_d_qx[k][QW-2:0], tx >= zz};
                r_d_qy[k+1] <= {r_d_qy[k][QW-2:0], ty >= zz};
            end
        end
    end

    // final: floor quotient, offset from center, round and saturate
    function automatic logic signed [15:0] scr_coord(
        input logic [QW-1:0]   q,
        input logic [REMW-1:0] rem,
        input logic            neg,
        input logic            ovf,
        input logic [13:0]     size
    );
        logic signed [QSW-1:0] qs;
        logic signed [SW-1:0]  v;
        logic signed [SW-1:0]  s;
        logic signed [15:0]    res;
        qs = $signed({2'b00, q});
        if (neg) begin
            qs = (rem != '0) ? -qs - QSW'(1) : -qs;
        end
        v = $signed({9'd0, size, 3'b000}) - SW'(qs);
        s = (v + SW'(8)) >>> 4;
        if (ovf) begin
            res = neg ? 16'sd32767 : -16'sd32768;
        end else if (s > SW'(32767)) begin
            res = 16'sd32767;
        end else if (s < -SW'(32768)) begin
            res = -16'sd32768;
        end else begin
            res = s[15:0];
        end
        return res;
    endfunction

    t_tag               r_f_tag;
    logic signed [15:0] r_f_sx, r_f_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_tag <= '0;
        end else if (en) begin
            r_f_tag <= r_d_side[QW].tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_sx <= scr_coord(r_d_qx[QW], r_d_rx[QW], r_d_side[QW].neg_x,
                                r_d_side[QW].ovf_x, r_scr_w);
            r_f_sy <= scr_coord(r_d_qy[QW], r_d_ry[QW], r_d_side[QW].neg_y,
                                r_d_side[QW].ovf_y, r_scr_h);
        end
    end

    // bounding rectangle over the corners of one box
    logic               r_any;
    logic signed [15:0] r_mnx, r_mny, r_mxx, r_mxy;
    logic               m_any;
    logic signed [15:0] m_mnx, m_mny, m_mxx, m_mxy;
    logic               m_vis;

    always_comb begin
        m_any = r_any;
        m_mnx = r_mnx;
        m_mny = r_mny;
        m_mxx = r_mxx;
        m_mxy = r_mxy;
        if (r_f_tag.use_c) begin
            m_any = 1'b1;
            if (!r_any || r_f_sx < r_mnx) m_mnx = r_f_sx;
            if (!r_any || r_f_sx > r_mxx) m_mxx = r_f_sx;
            if (!r_any || r_f_sy < r_mny) m_mny = r_f_sy;
            if (!r_any || r_f_sy > r_mxy) m_mxy = r_f_sy;
        end
        m_vis = m_any && !(m_mxx < 16'sd0 || 17'(m_mnx) > $signed({3'b000, r_scr_w}) ||
                           m_mxy < 16'sd0 || 17'(m_mny) > $signed({3'b000, r_scr_h}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
        end else if (en && r_f_tag.valid) begin
            r_any <= r_f_tag.last ? 1'b0 : m_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_f_tag.valid) begin
            r_mnx <= m_mnx;
            r_mny <= m_mny;
            r_mxx <= m_mxx;
            r_mxy <= m_mxy;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_f_tag.valid && r_f_tag.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_f_tag.valid && r_f_tag.last) begin
            o_visible      <= m_vis;
            o_min_screen_x <= m_any ? m_mnx : 16'sd0;
            o_min_screen_y <= m_any ? m_mny : 16'sd0;
            o_max_screen_x <= m_any ? m_mxx : 16'sd0;
            o_max_screen_y <= m_any ? m_mxy : 16'sd0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== bench/bpsb_checker.sv =====
// ----------------------------------------------------------------------------
// bpsb_checker
// Watches the box and rectangle channels of the screen-bounds unit, predicts
// each rectangle from its own copy of the camera registers and compares.
// ----------------------------------------------------------------------------
module bpsb_checker
    import bpsb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic signed [23:0]  i_rel_x,
    input  logic signed [23:0]  i_rel_y,
    input  logic signed [23:0]  i_rel_z,
    input  logic [9:0]          i_half_width,
    input  logic [10:0]         i_box_height,
    input  logic [9:0]          i_half_depth,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic                i_visible,
    input  logic signed [15:0]  i_min_screen_x,
    input  logic signed [15:0]  i_min_screen_y,
    input  logic signed [15:0]  i_max_screen_x,
    input  logic signed [15:0]  i_max_screen_y,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [IDXW-1:0]     i_cfg_index,
    input  logic [CFGW-1:0]     i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic               visible;
        logic signed [15:0] mnx;
        logic signed [15:0] mny;
        logic signed [15:0] mxx;
        logic signed [15:0] mxy;
    } t_rect;

    t_rect rect_queue[$];

    longint cam_cos_yaw, cam_sin_yaw, cam_cos_pitch, cam_sin_pitch;
    longint cam_focal, cam_width, cam_height;
    longint unsigned cam_cull_sq;

    function automatic longint div_floor(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && ((a < 0) != (b < 0)))
            q--;
        return q;
    endfunction

    function automatic longint shift_round(longint v, int n);
        return div_floor(v + (longint'(1) << (n - 1)), longint'(1) << n);
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic t_rect project_box(longint dx, longint dy, longint dz,
                                          longint hw, longint ht, longint hd);
        t_rect r;
        longint x, y, z, x1, z1, y1, y2, z2, x2, cx, cy, cz, sx, sy;
        longint mnx, mny, mxx, mxy;
        longint unsigned feet_sq;
        bit any;
        mnx = 0; mny = 0; mxx = 0; mxy = 0;
        any = 0;
        r = '0;
        feet_sq = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
        if (feet_sq <= cam_cull_sq) begin
            for (int c = 0; c < 8; c++) begin
                x = dx + (c[0] ? hw : -hw);
                y = dy + (c[1] ? ht : 0);
                z = dz + (c[2] ? hd : -hd);
                x1 = x * cam_cos_yaw + z * cam_sin_yaw;
                z1 = -x * cam_sin_yaw + z * cam_cos_yaw;
                y1 = y * 16384;
                y2 = y1 * cam_cos_pitch + z1 * cam_sin_pitch;
                z2 = -y1 * cam_sin_pitch + z1 * cam_cos_pitch;
                x2 = x1 * 16384;
                if (z2 <= longint'(NEAR_Q36))
                    continue;
                cx = shift_round(x2, 20);
                cy = shift_round(y2, 20);
                cz = shift_round(z2, 20);
                if (cz <= 0)
                    continue;
                sx = clamp16(shift_round(cam_width * 8 - div_floor(cx * cam_focal, cz), 4));
                sy = clamp16(shift_round(cam_height * 8 - div_floor(cy * cam_focal, cz), 4));
                if (!any) begin
                    mnx = sx; mxx = sx; mny = sy; mxy = sy;
                    any = 1;
                end else begin
                    if (sx < mnx) mnx = sx;
                    if (sx > mxx) mxx = sx;
                    if (sy < mny) mny = sy;
                    if (sy > mxy) mxy = sy;
                end
            end
            if (any)
                r.visible = !(mxx < 0 || mnx > cam_width || mxy < 0 || mny > cam_height);
        end
        r.mnx = mnx[15:0];
        r.mny = mny[15:0];
        r.mxx = mxx[15:0];
        r.mxy = mxy[15:0];
        return r;
    endfunction

    assign o_pending = rect_queue.size();

    always @(posedge i_clk) begin
        t_rect want;
        if (!i_rst_n) begin
            cam_cos_yaw <= 16384;
            cam_sin_yaw <= 0;
            cam_cos_pitch <= 16384;
            cam_sin_pitch <= 0;
            cam_focal <= 8192;
            cam_cull_sq <= 64'hFF_FFFF_FFFF;
            cam_width <= 1920;
            cam_height <= 1080;
            o_fail_count <= 0;
            rect_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_COS_YAW:     cam_cos_yaw <= longint'($signed(i_cfg_data[15:0]));
                    REG_SIN_YAW:     cam_sin_yaw <= longint'($signed(i_cfg_data[15:0]));
                    REG_COS_PITCH:   cam_cos_pitch <= longint'($signed(i_cfg_data[15:0]));
                    REG_SIN_PITCH:   cam_sin_pitch <= longint'($signed(i_cfg_data[15:0]));
                    REG_FOCAL_PX:    cam_focal <= longint'(i_cfg_data[19:0]);
                    REG_MAX_DIST_SQ: cam_cull_sq <= i_cfg_data;
                    REG_SCREEN_W:    cam_width <= longint'(i_cfg_data[13:0]);
                    REG_SCREEN_H:    cam_height <= longint'(i_cfg_data[13:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                rect_queue.insert(rect_queue.size(),
                    project_box(i_rel_x, i_rel_y, i_rel_z,
                                i_half_width, i_box_height, i_half_depth));
            if (i_out_valid && !i_out_stall) begin
                if (rect_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected rectangle beat: vis=%0d x %0d..%0d y %0d..%0d",
                            i_visible, i_min_screen_x, i_max_screen_x,
                            i_min_screen_y, i_max_screen_y);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = rect_queue.pop_front();
                    if (want.visible !== i_visible || want.mnx !== i_min_screen_x ||
                        want.mny !== i_min_screen_y || want.mxx !== i_max_screen_x ||
                        want.mxy !== i_max_screen_y) begin
                        if (o_fail_count < 10)
                            $display({"rect differs: want vis=%0d %0d %0d %0d %0d",
                                      " got %0d %0d %0d %0d %0d"},
                                want.visible, want.mnx, want.mny, want.mxx, want.mxy,
                                i_visible, i_min_screen_x, i_min_screen_y,
                                i_max_screen_x, i_max_screen_y);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives camera settings and boxes into the screen-bounds unit under random
// idling and back-pressure; the checker predicts and compares every rectangle.
// ----------------------------------------------------------------------------
module tb_top;
    import bpsb_pkg::*;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic signed [23:0] rel_x = 0, rel_y = 0, rel_z = 0;
    logic [9:0]         half_width = 0, half_depth = 0;
    logic [10:0]        box_height = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic               visible;
    logic signed [15:0] mnx, mny, mxx, mxy;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [IDXW-1:0]    cfg_index = '0;
    logic [CFGW-1:0]    cfg_data = '0;
    int                 fail_count, pending;
    int                 cycle_count = 0;
    bit                 hold_off = 0;
    bit                 calm = 0;
    bit                 stim_done = 0;

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    box_perspective_screen_bounds_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_rel_x(rel_x), .i_rel_y(rel_y), .i_rel_z(rel_z),
        .i_half_width(half_width), .i_box_height(box_height),
        .i_half_depth(half_depth),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_visible(visible), .o_min_screen_x(mnx), .o_min_screen_y(mny),
        .o_max_screen_x(mxx), .o_max_screen_y(mxy),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    bpsb_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_rel_x(rel_x), .i_rel_y(rel_y), .i_rel_z(rel_z),
        .i_half_width(half_width), .i_box_height(box_height),
        .i_half_depth(half_depth),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_visible(visible), .i_min_screen_x(mnx), .i_min_screen_y(mny),
        .i_max_screen_x(mxx), .i_max_screen_y(mxy),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("box_perspective_screen_bounds_unit: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off)
            out_stall <= 1;
        else if (calm)
            out_stall <= 0;
        else
            out_stall <= ($urandom_range(99) < 24);
    end

    task automatic write_reg(input logic [IDXW-1:0] idx, input logic [CFGW-1:0] val);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 0;
    endtask

    task automatic send_box(input logic signed [23:0] x, input logic signed [23:0] y,
                            input logic signed [23:0] z, input logic [9:0] hw,
                            input logic [10:0] ht, input logic [9:0] hd);
        while (!calm && $urandom_range(99) < 24) @(negedge i_clk);
        in_valid = 1;
        rel_x = x; rel_y = y; rel_z = z;
        half_width = hw; box_height = ht; half_depth = hd;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
        in_valid = 0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // mostly boxes within a few hundred blocks, sometimes the full range
    task automatic random_box();
        logic signed [23:0] x, y, z;
        if ($urandom_range(9) == 0) begin
            x = 24'($urandom); y = 24'($urandom); z = 24'($urandom);
        end else begin
            x = 24'($signed(24'($urandom_range(60000))) - 30000);
            y = 24'($signed(24'($urandom_range(20000))) - 10000);
            z = 24'($signed(24'($urandom_range(60000))) - 30000);
        end
        send_box(x, y, z, 10'($urandom), 11'($urandom), 10'($urandom));
    endtask

    task automatic set_camera(input int cy, input int sy, input int cp, input int sp,
                              input int focal, input longint cull, input int w,
                              input int h);
        write_reg(REG_COS_YAW, CFGW'(cy));
        write_reg(REG_SIN_YAW, CFGW'(sy));
        write_reg(REG_COS_PITCH, CFGW'(cp));
        write_reg(REG_SIN_PITCH, CFGW'(sp));
        write_reg(REG_FOCAL_PX, CFGW'(focal));
        write_reg(REG_MAX_DIST_SQ, CFGW'(cull));
        write_reg(REG_SCREEN_W, CFGW'(w));
        write_reg(REG_SCREEN_H, CFGW'(h));
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: reset camera
        send_box(0, 0, 2560, 77, 461, 77);
        send_box(0, 0, 25, 0, 0, 0);
        send_box(0, 0, 26, 0, 0, 0);
        send_box(0, 0, -2560, 100, 200, 100);
        send_box(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1023, 2047, 1023);
        send_box(-24'sh800000, -24'sh800000, -24'sh800000, 1023, 2047, 1023);
        send_box(100000, 0, 300, 10, 10, 10);
        send_box(0, -100000, 300, 10, 10, 10);
        send_box(0, 0, 30, 1023, 2047, 1023);
        send_box(-24'sh800000, 0, 24'sh7FFFFF, 0, 0, 0);
        drain();
        set_camera(0, 16384, 0, -16384, 1048575, 40000000, 8192, 8192);
        send_box(0, 0, 2560, 77, 461, 77);
        send_box(3000, 0, 0, 50, 50, 50);
        send_box(0, 3000, 0, 50, 50, 50);
        send_box(0, -3000, 0, 50, 50, 50);
        send_box(0, 0, 7000, 0, 0, 0);
        send_box(24'sh7FFFFF, 0, 0, 0, 0, 0);
        drain();
        set_camera(-16384, -16384, 16384, 16384, 0, 0, 1, 1);
        send_box(0, 0, 0, 1023, 2047, 1023);
        send_box(0, 0, 1, 5, 5, 5);
        send_box(1, 0, 0, 5, 5, 5);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_camera(16384, 0, 16384, 0, 8192, 64'hFF_FFFF_FFFF, 1920, 1080);
                1: set_camera(11585, 11585, 15137, -6270, 20000, 64'hFF_FFFF_FFFF, 2560, 1440);
                2: set_camera(-8192, 14189, 15137, 6270, 4096, 500000000, 800, 600);
                3: set_camera($urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                              $urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                              $urandom_range(1048575), {$urandom, $urandom},
                              $urandom_range(8191) + 1, $urandom_range(8191) + 1);
                4: set_camera(16384, -16384, -16384, 16384, 1048575, 900000000, 8192, 1);
                default: set_camera(0, -16384, 16384, 0, 1, 64'hFF_FFFF_FFFF, 16383, 16383);
            endcase
            for (int n = 0; n < 200; n++) begin
                if (phase == 1 && n == 50) calm = 1;
                if (phase == 1 && n == 120) calm = 0;
                if (phase == 3 && n == 100)
                    while (pending != 0) @(negedge i_clk);
                random_box();
            end
            drain();
        end

        // long hold-off while boxes keep coming, counted in its own process
        fork
            begin
                hold_off = 1;
                repeat (300) @(negedge i_clk);
                hold_off = 0;
            end
            for (int n = 0; n < 30; n++) random_box();
        join
        drain();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (fail_count == 0)
            $display("box_perspective_screen_bounds_unit: match");
        else
            $display("box_perspective_screen_bounds_unit: mismatch");
        $finish;
    end

endmodule

// ===== box_perspective_screen_bounds_unit.f =====
hw/rtl/bpsb_pkg.sv
hw/rtl/box_perspective_screen_bounds_unit.sv
bench/bpsb_checker.sv
bench/tb_top.sv
